@@ sv/scrollback_line_stack_core_defines.svh @@
// Assertion macros shared by the scrollback line stack RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef SCROLLBACK_LINE_STACK_CORE_DEFINES_SVH
`define SCROLLBACK_LINE_STACK_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SLC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slc: %m check failed");

// Next-cycle implication, disabled during reset
`define SLC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slc: %m check failed");

`endif

@@ sv/slc_pkg.sv @@
// Shared types and constants of the scrollback line stack.
// No dependencies; imported by every module and interface of the block.
package slc_pkg;

  // Store geometry
  localparam int ROWS     = 32;
  localparam int MAX_COLS = 64;

  // Field widths fixed by the interface
  localparam int CHAR_W  = 21;
  localparam int WIDTH_W = 2;
  localparam int STYLE_W = 56;
  localparam int CNT_W   = 6;
  localparam int POPC_W  = 7;

  // Derived widths
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int FILL_W  = $clog2(MAX_COLS + 2);
  localparam int LEN_W   = $clog2(MAX_COLS + 1) > POPC_W ? $clog2(MAX_COLS + 1) : POPC_W;
  localparam int MEM_DEPTH = ROWS * MAX_COLS;
  localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [CNT_W-1:0] MAX_ROWS_RST = CNT_W'(32);

  // Request kind codes
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_RESULT,
    CMD_POP
  } cmd_kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  cell_char;
    logic [WIDTH_W-1:0] cell_width;
    logic [STYLE_W-1:0] cell_style;
  } cell_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    cell_t              cell_data;
    logic               ok;
    logic               trunc;
    logic [CNT_W-1:0]   held;
    logic [CNT_W-1:0]   pending;
    logic [ROW_W-1:0]   slot;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   cols;
  } cmd_t;

endpackage

@@ sv/slc_in_if.sv @@
// Request channel of the scrollback line stack: valid/ready plus one request.
// Depends on slc_pkg for field widths.
interface slc_in_if import slc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [CHAR_W-1:0]  cell_char;
  logic [WIDTH_W-1:0] cell_width;
  logic [STYLE_W-1:0] cell_style;
  logic               last_cell;
  logic [POPC_W-1:0]  pop_cols;

  modport source(output valid, kind, cell_char, cell_width, cell_style, last_cell,
                 pop_cols, input ready);
  modport sink(input valid, kind, cell_char, cell_width, cell_style, last_cell,
               pop_cols, output ready);
endinterface

@@ sv/slc_out_if.sv @@
// Result channel of the scrollback line stack: valid/ready plus one result.
// Depends on slc_pkg for field widths.
interface slc_out_if import slc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [CHAR_W-1:0]  out_char;
  logic [WIDTH_W-1:0] out_width;
  logic [STYLE_W-1:0] out_style;
  logic               out_last;
  logic               truncated;
  logic [CNT_W-1:0]   rows_held;
  logic [CNT_W-1:0]   rows_pending;

  modport source(output valid, ok, out_char, out_width, out_style, out_last, truncated,
                 rows_held, rows_pending, input ready);
  modport sink(input valid, ok, out_char, out_width, out_style, out_last, truncated,
               rows_held, rows_pending, output ready);
endinterface

@@ sv/slc_front.sv @@
// Front end: accepts requests, keeps ring head, counts and row lengths,
// and turns each request into a command. Depends on slc_pkg, slc_in_if.
`include "scrollback_line_stack_core_defines.svh"
module slc_front import slc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  slc_in_if.sink           in_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output cmd_t             cmd,
  output logic             cmd_valid,
  input  logic             cmd_ready
);

  logic [CNT_W-1:0]  max_rows_r, max_rows_nxt;
  logic [ROW_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  stored_r, stored_nxt;
  logic [CNT_W-1:0]  pending_r, pending_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0]  row_len_r [ROWS];

  logic              acc;
  logic [CNT_W-1:0]  limit;
  logic [ROW_W-1:0]  slot_inc, slot_dec;
  logic [FILL_W-1:0] fill_tmp;
  logic              col_free;
  logic [CNT_W-1:0]  stored_inc, pending_inc;
  logic              len_we;
  logic [LEN_W-1:0]  len_wdata;
  logic [LEN_W-1:0]  cols_sat;

  assign acc       = in_ch.valid && in_ch.ready;
  assign cmd_valid = in_ch.valid;
  assign in_ch.ready = cmd_ready;

  // Effective row limit and ring neighbors
  assign limit    = (32'(max_rows_r) > ROWS) ? CNT_W'(ROWS) : max_rows_r;
  assign slot_inc = (head_r == ROW_W'(ROWS - 1)) ? '0 : head_r + 1'b1;
  assign slot_dec = (head_r == '0) ? ROW_W'(ROWS - 1) : head_r - 1'b1;

  // Column bookkeeping for a pushed cell
  assign col_free    = 32'(fill_r) < MAX_COLS;
  assign fill_tmp    = col_free ? fill_r + 1'b1 : FILL_W'(MAX_COLS + 1);
  assign stored_inc  = (stored_r < limit) ? stored_r + 1'b1 : stored_r;
  assign pending_inc = (pending_r < limit) ? pending_r + 1'b1 : pending_r;
  assign cols_sat    = (32'(in_ch.pop_cols) > MAX_COLS) ? LEN_W'(MAX_COLS)
                                                        : LEN_W'(in_ch.pop_cols);

  // Classify the request and compute the next bookkeeping state
  always_comb begin
    max_rows_nxt = cfg_we ? cfg_wdata : max_rows_r;
    head_nxt     = head_r;
    stored_nxt   = stored_r;
    pending_nxt  = pending_r;
    fill_nxt     = fill_r;
    len_we       = 1'b0;
    len_wdata    = (32'(fill_tmp) > MAX_COLS) ? LEN_W'(MAX_COLS) : LEN_W'(fill_tmp);
    cmd          = '0;
    cmd.kind     = CMD_NONE;
    cmd.held     = stored_r;
    cmd.pending  = pending_r;
    if (in_ch.kind == KIND_PUSH) begin
      cmd.wr_en                = col_free;
      cmd.wr_addr              = ADDR_W'(int'(slot_inc) * MAX_COLS + int'(fill_r));
      cmd.cell_data.cell_char  = in_ch.cell_char;
      cmd.cell_data.cell_width = in_ch.cell_width;
      cmd.cell_data.cell_style = in_ch.cell_style;
      if (acc) begin
        fill_nxt = fill_tmp;
      end
      if (in_ch.last_cell) begin
        cmd.kind  = CMD_RESULT;
        cmd.trunc = 32'(fill_tmp) > MAX_COLS;
        if (limit == '0) begin
          cmd.ok = 1'b0;
          if (acc) begin
            fill_nxt = '0;
          end
        end else begin
          cmd.ok      = 1'b1;
          cmd.held    = stored_inc;
          cmd.pending = pending_inc;
          if (acc) begin
            len_we      = 1'b1;
            head_nxt    = slot_inc;
            stored_nxt  = stored_inc;
            pending_nxt = pending_inc;
            fill_nxt    = '0;
          end
        end
      end
    end else begin
      if (acc) begin
        fill_nxt = '0;
      end
      if (stored_r == '0 || in_ch.pop_cols == '0) begin
        cmd.kind = CMD_RESULT;
        cmd.ok   = 1'b0;
      end else begin
        cmd.kind    = CMD_POP;
        cmd.ok      = 1'b1;
        cmd.slot    = head_r;
        cmd.len     = (32'(row_len_r[head_r]) > MAX_COLS) ? LEN_W'(MAX_COLS)
                                                          : row_len_r[head_r];
        cmd.cols    = cols_sat;
        cmd.held    = stored_r - 1'b1;
        cmd.pending = (pending_r != '0) ? pending_r - 1'b1 : pending_r;
        if (acc) begin
          head_nxt    = slot_dec;
          stored_nxt  = cmd.held;
          pending_nxt = cmd.pending;
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rows_r <= MAX_ROWS_RST;
      head_r     <= '0;
      stored_r   <= '0;
      pending_r  <= '0;
      fill_r     <= '0;
    end else begin
      max_rows_r <= max_rows_nxt;
      head_r     <= head_nxt;
      stored_r   <= stored_nxt;
      pending_r  <= pending_nxt;
      fill_r     <= fill_nxt;
    end
  end

  // Record the length of a committed row
  always_ff @(posedge clk) begin
    if (len_we) begin
      row_len_r[slot_inc] <= len_wdata;
    end
  end

  `SLC_ASSERT_IMPL(a_counts_bounded, 1'b1, (stored_r <= CNT_W'(ROWS)) && (pending_r <= CNT_W'(ROWS)))
  `SLC_ASSERT_IMPL(a_fill_range, 1'b1, fill_r <= FILL_W'(MAX_COLS + 1))
  `SLC_ASSERT_NEXT(a_commit_holds_row, acc && (in_ch.kind == KIND_PUSH) && in_ch.last_cell && (limit != '0), stored_r != '0)

endmodule

@@ sv/slc_cmd_fifo.sv @@
// Short command queue between the front and back ends.
// Depends on slc_pkg for cmd_t and the queue depth.
module slc_cmd_fifo import slc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t wr_cmd,
  input  logic wr_valid,
  output logic wr_ready,
  output cmd_t rd_cmd,
  output logic rd_valid,
  input  logic rd_ready
);

  cmd_t              q_r [Q_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = count_r != QCNT_W'(Q_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_cmd   = q_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Store an entering command
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= wr_cmd;
    end
  end

endmodule

@@ sv/slc_back.sv @@
// Back end: writes pushed cells into the cell memory, streams popped rows
// and drives the result register. Depends on slc_pkg, slc_out_if.
`include "scrollback_line_stack_core_defines.svh"
module slc_back import slc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_t     q_cmd,
  input  logic     q_valid,
  output logic     q_ready,
  slc_out_if.source out_ch
);

  cell_t              mem [MEM_DEPTH];
  cell_t              mem_q_r;

  logic [LEN_W-1:0]   col_r, col_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_ok_r, s1_ok_nxt;
  logic               s1_mem_r, s1_mem_nxt;
  logic [WIDTH_W-1:0] s1_width_r, s1_width_nxt;
  logic               s1_last_r, s1_last_nxt;
  logic               s1_trunc_r, s1_trunc_nxt;
  logic [CNT_W-1:0]   s1_held_r, s1_held_nxt;
  logic [CNT_W-1:0]   s1_pending_r, s1_pending_nxt;

  logic               load_ok;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               mem_we;
  logic               pop_pad, pop_last;

  assign load_ok  = !s1_valid_r || out_ch.ready;
  assign pop_pad  = col_r >= q_cmd.len;
  assign pop_last = (col_r + 1'b1) == q_cmd.cols;
  assign rd_addr  = ADDR_W'(int'(q_cmd.slot) * MAX_COLS + int'(col_r));
  assign mem_we   = q_valid && q_ready && q_cmd.wr_en;

  // Execute the command at the head of the queue
  always_comb begin
    q_ready        = 1'b0;
    rd_en          = 1'b0;
    col_nxt        = col_r;
    s1_valid_nxt   = s1_valid_r && !out_ch.ready;
    s1_ok_nxt      = s1_ok_r;
    s1_mem_nxt     = s1_mem_r;
    s1_width_nxt   = s1_width_r;
    s1_last_nxt    = s1_last_r;
    s1_trunc_nxt   = s1_trunc_r;
    s1_held_nxt    = s1_held_r;
    s1_pending_nxt = s1_pending_r;
    if (q_valid) begin
      case (q_cmd.kind)
        CMD_NONE: begin
          q_ready = 1'b1;
        end
        CMD_RESULT: begin
          if (load_ok) begin
            q_ready        = 1'b1;
            s1_valid_nxt   = 1'b1;
            s1_ok_nxt      = q_cmd.ok;
            s1_mem_nxt     = 1'b0;
            s1_width_nxt   = '0;
            s1_last_nxt    = 1'b1;
            s1_trunc_nxt   = q_cmd.trunc;
            s1_held_nxt    = q_cmd.held;
            s1_pending_nxt = q_cmd.pending;
          end
        end
        CMD_POP: begin
          if (load_ok) begin
            rd_en          = 1'b1;
            s1_valid_nxt   = 1'b1;
            s1_ok_nxt      = 1'b1;
            s1_mem_nxt     = !pop_pad;
            s1_width_nxt   = WIDTH_W'(1);
            s1_last_nxt    = pop_last;
            s1_trunc_nxt   = 1'b0;
            s1_held_nxt    = q_cmd.held;
            s1_pending_nxt = q_cmd.pending;
            if (pop_last) begin
              q_ready = 1'b1;
              col_nxt = '0;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
        default: begin
          q_ready = 1'b1;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    s1_ok_r      <= s1_ok_nxt;
    s1_mem_r     <= s1_mem_nxt;
    s1_width_r   <= s1_width_nxt;
    s1_last_r    <= s1_last_nxt;
    s1_trunc_r   <= s1_trunc_nxt;
    s1_held_r    <= s1_held_nxt;
    s1_pending_r <= s1_pending_nxt;
  end

  // Cell memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_cmd.wr_addr] <= q_cmd.cell_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Drive the result channel; padding and push results carry blank cells
  assign out_ch.valid        = s1_valid_r;
  assign out_ch.ok           = s1_ok_r;
  assign out_ch.out_char     = s1_mem_r ? mem_q_r.cell_char : '0;
  assign out_ch.out_width    = s1_mem_r ? mem_q_r.cell_width : s1_width_r;
  assign out_ch.out_style    = s1_mem_r ? mem_q_r.cell_style : '0;
  assign out_ch.out_last     = s1_last_r;
  assign out_ch.truncated    = s1_trunc_r;
  assign out_ch.rows_held    = s1_held_r;
  assign out_ch.rows_pending = s1_pending_r;

  `SLC_ASSERT_IMPL(a_col_only_in_pop, col_r != '0, q_valid && (q_cmd.kind == CMD_POP))
  `SLC_ASSERT_IMPL(a_pop_cmd_sane, q_valid && (q_cmd.kind == CMD_POP), (q_cmd.cols != '0) && (q_cmd.cols <= LEN_W'(MAX_COLS)) && (col_r < q_cmd.cols))
  `SLC_ASSERT_IMPL(a_no_write_on_pop, q_valid && (q_cmd.kind == CMD_POP), !mem_we)

endmodule

@@ sv/scrollback_line_stack_core.sv @@
// Scrollback line stack: a last-in-first-out store of up to max_rows text
// rows (at most 32, 64 cells each) that drops the oldest row when full. A
// pushed cell is taken every cycle while the command queue has room; the
// last cell of a row commits it and yields one result the same way a
// refused pop does. A pop yields pop_cols results (capped at 64), one per
// cycle while the result side is not stalled, read from the cell memory's
// registered read port, and the front end keeps taking up to three further
// requests into its queue meanwhile. The result leaves from a register. The
// cell memory is not cleared after reset; the block is ready at once.
// Depends on slc_pkg, slc_in_if, slc_out_if, slc_front, slc_cmd_fifo, slc_back.
module scrollback_line_stack_core import slc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  slc_in_if.sink           in_ch,
  slc_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  cmd_t front_cmd;
  logic front_valid, front_ready;
  cmd_t back_cmd;
  logic back_valid, back_ready;

  // Classify requests and keep bookkeeping
  slc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  // Decouple the two sides
  slc_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cmd   (front_cmd),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_cmd   (back_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  // Store cells and stream results
  slc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (back_cmd),
    .q_valid (back_valid),
    .q_ready (back_ready),
    .out_ch  (out_ch)
  );

endmodule
